// ===== src/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("u8d assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("u8d assertion failed");

`endif

// ===== src/u8d_pkg.sv =====
`default_nettype none

package u8d_pkg;

	localparam int CP_W         = 21;
	localparam int FIELD_OFF_W  = 24;
	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = 1;

	localparam logic [APB_ADDR_W-1:0] ADDR_STRIP_BOM = 1'b0;

	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] LEAD2_MIN = 8'hC2;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD4_MAX = 8'hF4;

	localparam logic [CP_W-1:0] MIN_LEN2 = 21'h00080;
	localparam logic [CP_W-1:0] MIN_LEN3 = 21'h00800;
	localparam logic [CP_W-1:0] MIN_LEN4 = 21'h10000;
	localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO  = 21'h0D800;
	localparam logic [CP_W-1:0] SURR_HI  = 21'h0DFFF;
	localparam logic [CP_W-1:0] BOM_CP   = 21'h0FEFF;

	localparam logic [FIELD_OFF_W-1:0] FIELD_OFF_MAX = 24'hFFFFFF;

	typedef enum logic [1:0] {
		ST_CHAR  = 2'd0,
		ST_END   = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	typedef struct packed {
		logic strip_bom;
	} cfg_t;

endpackage

`default_nettype wire

// ===== src/u8d_if.sv =====
`default_nettype none

interface u8d_in_if;
	import u8d_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface u8d_out_if;
	import u8d_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CP_W-1:0]        char_value;
	logic [1:0]             status;
	logic [FIELD_OFF_W-1:0] error_offset;
	logic                   has_bom;
	logic                   last;

	modport source (output valid, output char_value, output status, output error_offset,
		output has_bom, output last, input ready);
	modport sink   (input valid, input char_value, input status, input error_offset,
		input has_bom, input last, output ready);
endinterface

`default_nettype wire

// ===== src/u8d_cfg.sv =====
`default_nettype none

module u8d_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [u8d_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [u8d_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [u8d_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                  pready,
	output u8d_pkg::cfg_t                         cfg
);
	import u8d_pkg::*;

	logic strip_bom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_bom_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == ADDR_STRIP_BOM) begin
			strip_bom_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_STRIP_BOM) begin
			prdata = {{(APB_DATA_W-1){1'b0}}, strip_bom_q};
		end
	end

	assign pready        = 1'b1;
	assign cfg.strip_bom = strip_bom_q;

endmodule

`default_nettype wire

// ===== src/u8d_core.sv =====
`default_nettype none

module u8d_core #(
	parameter int OFFSET_BITS = 24
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire u8d_pkg::cfg_t cfg,
	u8d_in_if.sink     bytes,
	u8d_out_if.source  results
);
	import u8d_pkg::*;

	localparam int ExtW = (OFFSET_BITS > FIELD_OFF_W) ? OFFSET_BITS : FIELD_OFF_W;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic       adv;

	// Stream state.
	logic [CP_W-1:0]        part_q, part_n;
	logic [1:0]             pend_q, pend_n;
	logic [1:0]             len_q, len_n;
	logic [OFFSET_BITS-1:0] start_q, start_n;
	logic [OFFSET_BITS-1:0] cnt_q, cnt_n;
	logic                   bad_seen_q, bad_seen_n;
	logic [OFFSET_BITS-1:0] bad_off_q, bad_off_n;
	logic                   disc_q, disc_n;
	logic                   mark_q, mark_n;
	logic                   at_start_q, at_start_n;

	// Result register.
	logic                   out_valid_q;
	logic [CP_W-1:0]        cp_q;
	status_t                status_q;
	logic [FIELD_OFF_W-1:0] err_off_q;
	logic                   has_bom_q;
	logic                   last_q;

	// Decode outputs.
	logic                   has_res;
	logic                   emit;
	status_t                st;
	logic [CP_W-1:0]        cp;
	logic [OFFSET_BITS-1:0] err_off;
	logic [ExtW-1:0]        err_ext;
	logic [FIELD_OFF_W-1:0] err_field;
	logic                   mark_out;
	logic [CP_W-1:0]        minimum;

	assign adv         = valid_s1 && (!out_valid_q || results.ready);
	assign bytes.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data_byte;
			eos_s1  <= bytes.end_of_stream;
		end
	end

	always_comb begin
		part_n     = part_q;
		pend_n     = pend_q;
		len_n      = len_q;
		start_n    = start_q;
		bad_seen_n = bad_seen_q;
		bad_off_n  = bad_off_q;
		disc_n     = disc_q;
		mark_n     = mark_q;
		at_start_n = at_start_q;
		cnt_n      = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
		has_res    = 1'b0;
		st         = ST_END;
		cp         = '0;
		err_off    = '0;
		minimum    = MIN_LEN4;

		if (disc_q) begin
			// Bytes after an error are dropped until the stream ends.
		end else if (pend_q == 2'd0) begin
			start_n    = cnt_q;
			bad_seen_n = 1'b0;
			bad_off_n  = '0;
			case (byte_s1) inside
				[8'h00:ASCII_MAX]: begin
					has_res    = 1'b1;
					st         = ST_CHAR;
					cp         = {{(CP_W-8){1'b0}}, byte_s1};
					at_start_n = 1'b0;
				end
				[LEAD2_MIN:LEAD2_MAX]: begin
					pend_n = 2'd1;
					len_n  = 2'd1;
					part_n = {{(CP_W-5){1'b0}}, byte_s1[4:0]};
				end
				[LEAD3_MIN:LEAD3_MAX]: begin
					pend_n = 2'd2;
					len_n  = 2'd2;
					part_n = {{(CP_W-4){1'b0}}, byte_s1[3:0]};
				end
				[LEAD4_MIN:LEAD4_MAX]: begin
					pend_n = 2'd3;
					len_n  = 2'd3;
					part_n = {{(CP_W-3){1'b0}}, byte_s1[2:0]};
				end
				default: begin
					has_res    = 1'b1;
					st         = ST_ERROR;
					err_off    = cnt_q;
					at_start_n = 1'b0;
				end
			endcase
			if (pend_n != 2'd0 && eos_s1) begin
				has_res = 1'b1;
				st      = ST_ERROR;
				err_off = cnt_q;
			end
		end else begin
			if (byte_s1[7:6] != 2'b10 && !bad_seen_q) begin
				bad_seen_n = 1'b1;
				bad_off_n  = cnt_q;
			end
			part_n = {part_q[CP_W-7:0], byte_s1[5:0]};
			pend_n = pend_q - 2'd1;
			case (len_q)
				2'd1:    minimum = MIN_LEN2;
				2'd2:    minimum = MIN_LEN3;
				default: minimum = MIN_LEN4;
			endcase
			if (pend_n == 2'd0) begin
				if (bad_seen_n) begin
					has_res = 1'b1;
					st      = ST_ERROR;
					err_off = bad_off_n;
				end else if (part_n < minimum || part_n > CP_MAX ||
					(part_n >= SURR_LO && part_n <= SURR_HI)) begin
					has_res = 1'b1;
					st      = ST_ERROR;
					err_off = start_q;
				end else if (cfg.strip_bom && at_start_q && len_q == 2'd2 &&
					part_n == BOM_CP) begin
					mark_n = 1'b1;
					cnt_n  = '0;
				end else begin
					has_res = 1'b1;
					st      = ST_CHAR;
					cp      = part_n;
				end
				at_start_n = 1'b0;
			end else if (eos_s1) begin
				has_res = 1'b1;
				st      = ST_ERROR;
				err_off = start_q;
			end
		end

		if (has_res && st == ST_ERROR) begin
			pend_n = 2'd0;
			if (!eos_s1) begin
				disc_n = 1'b1;
			end
		end

		emit     = has_res || eos_s1;
		mark_out = mark_n;

		if (eos_s1) begin
			part_n     = '0;
			pend_n     = 2'd0;
			len_n      = 2'd0;
			start_n    = '0;
			cnt_n      = '0;
			bad_seen_n = 1'b0;
			bad_off_n  = '0;
			disc_n     = 1'b0;
			mark_n     = 1'b0;
			at_start_n = 1'b1;
		end
	end

	assign err_ext   = ExtW'(err_off);
	assign err_field = (err_ext > ExtW'(FIELD_OFF_MAX)) ? FIELD_OFF_MAX
		: err_ext[FIELD_OFF_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q     <= '0;
			pend_q     <= 2'd0;
			len_q      <= 2'd0;
			start_q    <= '0;
			cnt_q      <= '0;
			bad_seen_q <= 1'b0;
			bad_off_q  <= '0;
			disc_q     <= 1'b0;
			mark_q     <= 1'b0;
			at_start_q <= 1'b1;
		end else if (adv) begin
			part_q     <= part_n;
			pend_q     <= pend_n;
			len_q      <= len_n;
			start_q    <= start_n;
			cnt_q      <= cnt_n;
			bad_seen_q <= bad_seen_n;
			bad_off_q  <= bad_off_n;
			disc_q     <= disc_n;
			mark_q     <= mark_n;
			at_start_q <= at_start_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			cp_q      <= cp;
			status_q  <= st;
			err_off_q <= (st == ST_ERROR) ? err_field : '0;
			has_bom_q <= mark_out;
			last_q    <= eos_s1;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.char_value   = cp_q;
	assign results.status       = status_q;
	assign results.error_offset = err_off_q;
	assign results.has_bom      = has_bom_q;
	assign results.last         = last_q;

endmodule

`default_nettype wire

// ===== src/utf8_stream_decoder.sv =====
// Strict UTF-8 stream decoder.
// The bytes channel takes one raw word per cycle: data_byte and end_of_stream,
// which marks the final byte of a stream. The results channel gives at most one
// word per byte: a code point, an invalid-sequence report with its byte offset,
// or a plain end-of-stream marker. The final byte of a stream always yields a
// word with last set. Bytes that only continue a sequence yield nothing.
// A byte passes an input register and the decode logic, and its result is then
// registered in the output register. The decoder takes one byte per cycle for
// as long as the results side takes its words, since the only stage state
// carried between bytes is the small sequence state, updated as each byte
// is decoded.
// When the results side stalls, the output register holds its word, one more
// byte may wait in the input register, and then bytes.ready drops.
// The strip_bom register at address 0 of the APB port removes a leading
// byte order mark of each stream; write it only while the decoder is idle.
// Reset clears the stream state and strip_bom and empties both registers.
`default_nettype none

module utf8_stream_decoder #(
	parameter int OFFSET_BITS = 24
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	u8d_in_if.sink                                bytes,
	u8d_out_if.source                             results,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [u8d_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [u8d_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [u8d_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                  pready
);
	import u8d_pkg::*;

	cfg_t cfg;

	u8d_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	u8d_core #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.bytes   (bytes),
		.results (results)
	);

endmodule

`default_nettype wire

// ===== src/u8d_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module u8d_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic [u8d_pkg::CP_W-1:0]            char_value,
	input wire logic [1:0]                          status,
	input wire logic [u8d_pkg::FIELD_OFF_W-1:0]     error_offset,
	input wire logic                                has_bom,
	input wire logic                                last
);
	import u8d_pkg::*;

	`U8D_ASSERT_NOW(a_cp_only_on_char, clk, arst_n, out_valid && status != ST_CHAR, char_value == '0)
	`U8D_ASSERT_NOW(a_off_only_on_err, clk, arst_n, out_valid && status != ST_ERROR, error_offset == '0)
	`U8D_ASSERT_NOW(a_end_is_last, clk, arst_n, out_valid && status == ST_END, last)
	`U8D_ASSERT_NEXT(a_hold_on_stall, clk, arst_n, out_valid && !out_ready, out_valid && $stable(char_value) && $stable(status) && $stable(error_offset) && $stable(has_bom) && $stable(last))

endmodule

bind utf8_stream_decoder u8d_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.char_value   (results.char_value),
	.status       (results.status),
	.error_offset (results.error_offset),
	.has_bom      (results.has_bom),
	.last         (results.last)
);

`default_nettype wire

// ===== tb/sv/utf8_stream_decoder_tb.sv =====
import u8d_pkg::*;

// Tracks the decoder's stream state and queues the word, if any, that each accepted byte should produce.
class utf8_decode_board;
	typedef struct {
		logic [CP_W-1:0]        char_value;
		status_t                status;
		logic [FIELD_OFF_W-1:0] error_offset;
		logic                   has_bom;
		logic                   last;
	} decoded_t;

	decoded_t owed_words[$];
	int mismatches;
	bit strip_mark;

	logic [CP_W-1:0]        partial;
	bit [1:0]               need;
	bit [1:0]               seq_len;
	logic [FIELD_OFF_W-1:0] seq_start;
	logic [FIELD_OFF_W-1:0] counter;
	bit                     bad_seen;
	logic [FIELD_OFF_W-1:0] bad_off;
	bit                     discarding;
	bit                     mark;
	bit                     at_start;

	function new();
		mismatches = 0;
		strip_mark = 1'b0;
		clear_stream();
	endfunction

	function void clear_stream();
		partial = '0;
		need = 2'd0;
		seq_len = 2'd0;
		seq_start = '0;
		counter = '0;
		bad_seen = 1'b0;
		bad_off = '0;
		discarding = 1'b0;
		mark = 1'b0;
		at_start = 1'b1;
	endfunction

	function void take_byte(logic [7:0] b, logic eos);
		decoded_t r;
		logic [FIELD_OFF_W-1:0] off;
		logic [CP_W-1:0] lowest;
		bit found;
		off = counter;
		found = 1'b0;
		r.char_value = '0;
		r.status = ST_END;
		r.error_offset = '0;
		if (counter != '1)
			counter++;
		if (!discarding) begin
			if (need == 2'd0) begin
				seq_start = off;
				bad_seen = 1'b0;
				bad_off = '0;
				if (b <= ASCII_MAX) begin
					found = 1'b1;
					r.status = ST_CHAR;
					r.char_value = {13'd0, b};
					at_start = 1'b0;
				end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
					need = 2'd1;
					seq_len = 2'd1;
					partial = {16'd0, b[4:0]};
				end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
					need = 2'd2;
					seq_len = 2'd2;
					partial = {17'd0, b[3:0]};
				end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
					need = 2'd3;
					seq_len = 2'd3;
					partial = {18'd0, b[2:0]};
				end else begin
					found = 1'b1;
					r.status = ST_ERROR;
					r.error_offset = off;
					at_start = 1'b0;
				end
				if (need != 2'd0 && eos) begin
					found = 1'b1;
					r.status = ST_ERROR;
					r.error_offset = seq_start;
				end
			end else begin
				if (b[7:6] != 2'b10 && !bad_seen) begin
					bad_seen = 1'b1;
					bad_off = off;
				end
				partial = {partial[14:0], b[5:0]};
				need--;
				if (need == 2'd0) begin
					lowest = (seq_len == 2'd1) ? MIN_LEN2 :
						(seq_len == 2'd2) ? MIN_LEN3 : MIN_LEN4;
					if (bad_seen) begin
						found = 1'b1;
						r.status = ST_ERROR;
						r.error_offset = bad_off;
					end else if (partial < lowest || partial > CP_MAX ||
						(partial >= SURR_LO && partial <= SURR_HI)) begin
						found = 1'b1;
						r.status = ST_ERROR;
						r.error_offset = seq_start;
					end else if (strip_mark && at_start && seq_len == 2'd2 &&
						partial == BOM_CP) begin
						mark = 1'b1;
						counter = '0;
					end else begin
						found = 1'b1;
						r.status = ST_CHAR;
						r.char_value = partial;
					end
					at_start = 1'b0;
				end else if (eos) begin
					found = 1'b1;
					r.status = ST_ERROR;
					r.error_offset = seq_start;
				end
			end
		end
		if (found && r.status == ST_ERROR) begin
			need = 2'd0;
			if (!eos)
				discarding = 1'b1;
		end
		if (!found && !eos)
			return;
		r.has_bom = mark;
		r.last = eos;
		owed_words = {owed_words, r};
		if (eos)
			clear_stream();
	endfunction

	function void check_word(logic [CP_W-1:0] cp, logic [1:0] st,
		logic [FIELD_OFF_W-1:0] eoff, logic hb, logic lst);
		decoded_t want;
		if (owed_words.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected word: cp=%h status=%0d offset=%h bom=%b last=%b",
					cp, st, eoff, hb, lst);
			return;
		end
		want = owed_words.pop_front();
		if (cp !== want.char_value || st !== want.status || eoff !== want.error_offset ||
			hb !== want.has_bom || lst !== want.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"word mismatch: expected cp=%h status=%0d offset=%h bom=%b last=%b,",
					" got cp=%h status=%0d offset=%h bom=%b last=%b"},
					want.char_value, want.status, want.error_offset, want.has_bom, want.last,
					cp, st, eoff, hb, lst);
		end
	endfunction
endclass

module utf8_stream_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 240;
	localparam int PHASE_BYTES  = 120;

	typedef enum int {
		RX_OPEN,
		RX_RANDOM,
		RX_PATTERN,
		RX_SPARSE
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	u8d_in_if  bytes_if();
	u8d_out_if results_if();

	utf8_decode_board board = new();

	rx_mode_t rx_mode = RX_OPEN;
	int holds_asked = 0;
	bit steady = 1'b1;
	int burst_left = 1;
	logic [7:0] stream[$];

	utf8_stream_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes_if),
		.results(results_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin : receiver
		int hold_left;
		int holds_done;
		int beat;
		hold_left = 0;
		holds_done = 0;
		beat = 0;
		results_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			beat++;
			if (holds_done != holds_asked) begin
				holds_done = holds_asked;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				results_if.ready <= 1'b0;
				hold_left--;
			end else begin
				case (rx_mode)
					RX_OPEN: results_if.ready <= 1'b1;
					RX_RANDOM: results_if.ready <= ($urandom_range(0, 3) != 0);
					RX_PATTERN: results_if.ready <= ((beat % 7) < 4);
					default: results_if.ready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready)
			board.check_word(results_if.char_value, results_if.status,
				results_if.error_offset, results_if.has_bom, results_if.last);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((bytes_if.valid && bytes_if.ready) || (results_if.valid && results_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	function automatic void add_byte(logic [7:0] b);
		stream = {stream, b};
	endfunction

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom)};
	endfunction

	function automatic void put_scalar(logic [CP_W-1:0] cp);
		if (cp < 21'h80) begin
			add_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			add_byte({3'b110, cp[10:6]});
			add_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			add_byte({4'b1110, cp[15:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end else begin
			add_byte({5'b11110, cp[20:18]});
			add_byte({2'b10, cp[17:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end
	endfunction

	function automatic logic [CP_W-1:0] pick_scalar();
		logic [CP_W-1:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = 21'($urandom_range(0, 'h7F));
			2: v = 21'($urandom_range('h80, 'h7FF));
			3: begin
				v = 21'($urandom_range('h800, 'hFFFF));
				if (v >= SURR_LO && v <= SURR_HI)
					v = v ^ 21'h4000;
			end
			4: v = 21'($urandom_range('h10000, 'h10FFFF));
			default: begin
				case ($urandom_range(0, 10))
					0: v = 21'h0;
					1: v = 21'h7F;
					2: v = 21'h80;
					3: v = 21'h7FF;
					4: v = 21'h800;
					5: v = 21'hD7FF;
					6: v = 21'hE000;
					7: v = 21'hFFFF;
					8: v = 21'h10000;
					9: v = CP_MAX;
					default: v = BOM_CP;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic void put_fault();
		logic [7:0] b;
		int len;
		int at;
		case ($urandom_range(0, 5))
			0: begin
				if ($urandom_range(0, 1))
					add_byte(8'($urandom_range('h80, 'hC1)));
				else
					add_byte(8'($urandom_range('hF5, 'hFF)));
			end
			1: begin
				if ($urandom_range(0, 1)) begin
					add_byte(LEAD3_MIN);
					add_byte(8'($urandom_range('h80, 'h9F)));
					add_byte(cont_byte());
				end else begin
					add_byte(LEAD4_MIN);
					add_byte(8'($urandom_range('h80, 'h8F)));
					add_byte(cont_byte());
					add_byte(cont_byte());
				end
			end
			2: begin
				add_byte(8'hED);
				add_byte(8'($urandom_range('hA0, 'hBF)));
				add_byte(cont_byte());
			end
			3: begin
				add_byte(LEAD4_MAX);
				add_byte(8'($urandom_range('h90, 'hBF)));
				add_byte(cont_byte());
				add_byte(cont_byte());
			end
			4: begin
				len = $urandom_range(1, 3);
				at = $urandom_range(1, len);
				if (len == 1)
					add_byte(8'($urandom_range('hC2, 'hDF)));
				else if (len == 2)
					add_byte(8'($urandom_range('hE1, 'hEC)));
				else
					add_byte(8'($urandom_range('hF1, 'hF3)));
				for (int i = 1; i <= len; i++) begin
					b = 8'($urandom);
					if (i < at)
						b = cont_byte();
					else if (i == at && b[7:6] == 2'b10)
						b[6] = 1'b1;
					add_byte(b);
				end
			end
			default: add_byte(8'($urandom));
		endcase
	endfunction

	function automatic void put_truncated();
		int len;
		len = $urandom_range(1, 3);
		if (len == 1)
			add_byte(8'($urandom_range(LEAD2_MIN, LEAD2_MAX)));
		else if (len == 2)
			add_byte(8'($urandom_range(LEAD3_MIN, LEAD3_MAX)));
		else
			add_byte(8'($urandom_range(LEAD4_MIN, LEAD4_MAX)));
		repeat ($urandom_range(0, len - 1))
			add_byte(cont_byte());
	endfunction

	function automatic void build_random_stream();
		int pick;
		int fault_pct;
		stream.delete();
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			repeat ($urandom_range(1, 10))
				add_byte(8'($urandom));
		end else begin
			fault_pct = (pick < 45) ? 30 : 0;
			if ($urandom_range(0, 2) == 0) begin
				add_byte(8'hEF);
				add_byte(8'hBB);
				add_byte(8'hBF);
			end
			repeat ($urandom_range(0, 8)) begin
				if ($urandom_range(0, 99) < fault_pct)
					put_fault();
				else
					put_scalar(pick_scalar());
			end
			if ($urandom_range(0, 9) == 0)
				put_truncated();
			if (stream.size() == 0)
				put_scalar(pick_scalar());
		end
	endfunction

	task automatic send_word(input logic [7:0] b, input logic eos);
		bytes_if.valid <= 1'b1;
		bytes_if.data_byte <= b;
		bytes_if.end_of_stream <= eos;
		@(posedge clk);
		while (!bytes_if.ready)
			@(posedge clk);
		board.take_byte(b, eos);
		if (!steady) begin
			burst_left--;
			if (burst_left <= 0) begin
				bytes_if.valid <= 1'b0;
				repeat ($urandom_range(1, 6))
					@(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	task automatic send_stream();
		for (int i = 0; i < stream.size(); i++)
			send_word(stream[i], i == stream.size() - 1);
	endtask

	task automatic drain_all();
		bytes_if.valid <= 1'b0;
		@(posedge clk);
		while (board.owed_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_strip(input bit v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_STRIP_BOM;
		pwdata <= APB_DATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.strip_mark = v;
		@(posedge clk);
	endtask

	initial begin : stimulus
		int sent;
		bytes_if.valid = 1'b0;
		bytes_if.data_byte = '0;
		bytes_if.end_of_stream = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		stream = '{8'h00, 8'hC2, 8'h80, 8'hFF, 8'h7F};
		send_stream();
		stream = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_stream();
		stream = '{8'hE2, 8'h41, 8'h82};
		send_stream();
		stream = '{8'hE2, 8'h41};
		send_stream();
		stream = '{8'hED, 8'hA0, 8'h80};
		send_stream();
		drain_all();
		write_strip(1'b1);
		stream = '{8'hEF, 8'hBB, 8'hBF};
		send_stream();
		stream = '{8'hEF, 8'hBB, 8'hBF, 8'h7F};
		send_stream();

		for (int phase = 0; phase < 6; phase++) begin
			drain_all();
			write_strip((phase % 3) != 0);
			rx_mode = rx_mode_t'(phase % 4);
			steady = (phase == 0);
			burst_left = $urandom_range(1, 24);
			if (phase == 2)
				holds_asked++;
			sent = 0;
			while (sent < PHASE_BYTES) begin
				build_random_stream();
				send_stream();
				sent += stream.size();
			end
		end
		rx_mode = RX_RANDOM;
		drain_all();

		if (board.mismatches == 0 && board.owed_words.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+src
src/u8d_pkg.sv
src/u8d_if.sv
src/u8d_cfg.sv
src/u8d_core.sv
src/utf8_stream_decoder.sv
src/u8d_checker.sv
tb/sv/utf8_stream_decoder_tb.sv
